[rtl/spq_pkg.sv]
// Shared constants, codes and control structs for the scan priority queue.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LARGEST_FIRST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 8'd1;

    typedef struct packed {
        logic load;
        logic scan;
        logic shift_start;
        logic shift;
        logic finish;
    } spq_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic shift_any;
        logic shift_more;
        logic out_free;
    } spq_sts_t;

endpackage

[rtl/spq_dpath.sv]
// Datapath: entry memory, count, scan comparator, config registers and result register.
module spq_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  spq_pkg::spq_cmd_t              cmd,
    output spq_pkg::spq_sts_t              sts,
    input  logic                           s_kind,
    input  logic signed [spq_pkg::VAL_W-1:0] s_value,
    input  logic                           cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spq_pkg::CFG_DAT_W-1:0]  cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           m_ok,
    output logic signed [spq_pkg::VAL_W-1:0] m_taken
);
    import spq_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic signed [VAL_W-1:0] mem_wd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_sel;

    logic [IDX_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0] best_pos_reg;
    logic signed [VAL_W-1:0] best_reg;
    logic             kind_reg;
    logic             ok_pend_reg;
    logic [CNT_W-1:0] count_reg;
    logic             largest_first_reg;
    logic [CAP_W-1:0] capacity_reg;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic signed [VAL_W-1:0] out_taken_reg;

    logic [CMP_W-1:0] limit;
    logic             can_insert;
    logic [CNT_W-1:0] rd_next_cnt;
    logic [CNT_W-1:0] best_next_cnt;
    logic             better;

    // Capacity above the depth saturates at the depth
    assign limit = (CMP_W'(capacity_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                            : CMP_W'(capacity_reg);
    assign can_insert    = CMP_W'(count_reg) < limit;
    assign rd_next_cnt   = CNT_W'(rd_addr_reg) + CNT_W'(1);
    assign best_next_cnt = CNT_W'(best_pos_reg) + CNT_W'(1);
    assign better = largest_first_reg ? (rdata_reg > best_reg) : (best_reg > rdata_reg);

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = (rd_next_cnt == count_reg);
    assign sts.shift_any  = (best_next_cnt < count_reg);
    assign sts.shift_more = (rd_next_cnt < count_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = s_value;
        rd_en  = 1'b0;
        rd_sel = '0;
        if (cmd.load) begin
            rd_en  = 1'b1;
            rd_sel = '0;
            if (s_kind == KIND_INSERT && can_insert) begin
                mem_we = 1'b1;
                mem_wa = count_reg[IDX_W-1:0];
            end
        end
        if (cmd.scan && !sts.scan_last) begin
            rd_en  = 1'b1;
            rd_sel = rd_addr_reg + IDX_W'(1);
        end
        if (cmd.shift_start && sts.shift_any) begin
            rd_en  = 1'b1;
            rd_sel = best_pos_reg + IDX_W'(1);
        end
        if (cmd.shift) begin
            // close the gap: entry at rd_addr moves one place forward
            mem_we = 1'b1;
            mem_wa = rd_addr_reg - IDX_W'(1);
            mem_wd = rdata_reg;
            if (sts.shift_more) begin
                rd_en  = 1'b1;
                rd_sel = rd_addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_addr_reg <= rd_sel;
        end
        if (cmd.load) begin
            kind_reg    <= s_kind;
            ok_pend_reg <= (s_kind == KIND_INSERT) ? can_insert : !sts.count_zero;
        end
        // oldest entry wins on ties
        if (cmd.scan && (rd_addr_reg == '0 || better)) begin
            best_reg     <= rdata_reg;
            best_pos_reg <= rd_addr_reg;
        end
        if (cmd.finish) begin
            out_ok_reg    <= ok_pend_reg;
            out_taken_reg <= (kind_reg == KIND_REMOVE && ok_pend_reg) ? best_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= '0;
            largest_first_reg <= 1'b1;
            capacity_reg      <= CAP_RESET;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_LARGEST_FIRST: largest_first_reg <= cfg_data[0];
                    REG_CAPACITY:      capacity_reg      <= cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish && ok_pend_reg) begin
                if (kind_reg == KIND_INSERT) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_ok     = out_ok_reg;
    assign m_taken  = out_taken_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && ok_pend_reg && kind_reg == KIND_REMOVE
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("successful removal did not drop count");

    a_refused_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && s_kind == KIND_INSERT && !can_insert |-> !mem_we)
        else $error("refused insert wrote memory");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ok_reg |-> out_taken_reg == '0)
        else $error("failed item carries a value");

endmodule

[rtl/spq_ctrl.sv]
// Controller: sequences accept, scan, shift and result hand-off for one item.
module spq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_kind,
    input  spq_pkg::spq_sts_t  sts,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SHIFT0 = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_kind == KIND_REMOVE && !sts.count_zero) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SHIFT0;
                end
            end
            ST_SHIFT0: begin
                cmd.shift_start = 1'b1;
                state_next = sts.shift_any ? ST_SHIFT : ST_FIN;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (!sts.shift_more) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the result register to free up
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg != ST_IDLE)
        else $error("accepted item left controller idle");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan, cmd.shift_start, cmd.shift, cmd.finish}))
        else $error("conflicting datapath commands");

    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready)
        else $error("not ready after result hand-off");

endmodule

[rtl/scan_priority_queue.sv]
// Top level of the bounded priority queue with linear scan removal.
// One item at a time. Insert, or removal from empty: accepted, then the result is
// registered in the finish state. Removal of n stored entries: a scan of all n entries
// with one comparator over the memory read port, then the entries behind the taken one
// shift forward. A waiting result does not block acceptance; the next item holds in
// its finish state until the result is taken.
// Reset clears the count, sets largest_first=1, capacity=16; memory is not cleared.
module scan_priority_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spq_pkg::VAL_W-1:0]         s_tdata,   // [31:0] value
    input  logic                              s_tuser,   // [0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spq_pkg::VAL_W-1:0]         m_tdata,   // [31:0] taken
    output logic                              m_tuser,   // [0] ok
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spq_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import spq_pkg::*;

    spq_cmd_t cmd;
    spq_sts_t sts;
    logic signed [VAL_W-1:0] taken;

    assign cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_kind    (s_tuser),
        .s_value   (s_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_ok      (m_tuser),
        .m_taken   (taken)
    );

    assign m_tdata = taken;

endmodule
